// ===== rtl/npti_pkg.sv =====
// shared types, constants and codes for the nearest point time interpolator
package npti_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int TOL_W           = 16;
  localparam int DATA_W          = 32;
  // divider: numerator is a 32-bit magnitude shifted up by the fraction bits
  localparam int NUM_W           = DATA_W + FRAC_BITS;
  localparam int DEN_W           = DATA_W;
  // bracket weight stays below one plus tolerance over the smallest step
  localparam int WA_W            = 34;
  localparam int WA_LO_W         = 17;
  localparam int WGT_W           = 19;

  // opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // kind of result word to emit
  typedef enum logic [2:0] {
    RK_ZERO   = 3'd0,
    RK_FULL   = 3'd1,
    RK_EMPTY  = 3'd2,
    RK_HOLD   = 3'd3,
    RK_INTERP = 3'd4
  } res_kind_t;

  // controller to datapath
  typedef struct packed {
    logic      capture;
    logic      clr;
    logic      grp_run;
    logic      ent_run;
    logic      wr_entry;
    logic      decide;
    logic      div_go;
    logic      div_sel;
    logic      mul_go;
    logic      mul_hi;
    logic      fin;
    logic      out_load;
    res_kind_t kind;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic grp_done;
    logic ent_done;
    logic bracket;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/npti_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
module npti_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             qbit;

  // trial subtract of the next numerator bit
  always_comb begin
    trial = {rem_r, num_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    qbit  = (trial >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(NUM_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (run_r) begin
      rem_r <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_r <= {num_r[NUM_W-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

// ===== rtl/npti_ctrl.sv =====
// sequencing state machine for load, clear and query
module npti_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_opcode,
  output logic           in_ready,
  input  npti_pkg::sts_t sts,
  output npti_pkg::cmd_t cmd
);
  import npti_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_CLR     = 15'b000000000000010,
    S_LSCAN   = 15'b000000000000100,
    S_LWR     = 15'b000000000001000,
    S_QGRP    = 15'b000000000010000,
    S_QENT    = 15'b000000000100000,
    S_DEC     = 15'b000000001000000,
    S_DIVA_GO = 15'b000000010000000,
    S_DIVA    = 15'b000000100000000,
    S_DIVB_GO = 15'b000001000000000,
    S_DIVB    = 15'b000010000000000,
    S_MLO     = 15'b000100000000000,
    S_MHI     = 15'b001000000000000,
    S_FIN     = 15'b010000000000000,
    S_OUT     = 15'b100000000000000
  } state_t;

  state_t    state_r, state_nxt;
  res_kind_t kind_r, kind_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_opcode)
            OP_CLEAR: begin
              state_nxt = S_CLR;
              kind_nxt  = RK_ZERO;
            end
            OP_LOAD: begin
              if (sts.full) begin
                state_nxt = S_OUT;
                kind_nxt  = RK_FULL;
              end else begin
                state_nxt = S_LSCAN;
                kind_nxt  = RK_ZERO;
              end
            end
            OP_QUERY: begin
              if (sts.empty) begin
                state_nxt = S_OUT;
                kind_nxt  = RK_EMPTY;
              end else begin
                state_nxt = S_QGRP;
              end
            end
            default: begin
              state_nxt = S_OUT;
              kind_nxt  = RK_ZERO;
            end
          endcase
        end
      end
      S_CLR: begin
        cmd.clr   = 1'b1;
        state_nxt = S_OUT;
      end
      S_LSCAN: begin
        cmd.grp_run = 1'b1;
        if (sts.grp_done) state_nxt = S_LWR;
      end
      S_LWR: begin
        cmd.wr_entry = 1'b1;
        state_nxt    = S_OUT;
      end
      S_QGRP: begin
        cmd.grp_run = 1'b1;
        if (sts.grp_done) state_nxt = S_QENT;
      end
      S_QENT: begin
        cmd.ent_run = 1'b1;
        if (sts.ent_done) state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        if (sts.bracket) begin
          state_nxt = S_DIVA_GO;
          kind_nxt  = RK_INTERP;
        end else begin
          state_nxt = S_OUT;
          kind_nxt  = RK_HOLD;
        end
      end
      S_DIVA_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DIVA;
      end
      S_DIVA: begin
        if (sts.div_done) state_nxt = S_DIVB_GO;
      end
      S_DIVB_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = 1'b1;
        state_nxt   = S_DIVB;
      end
      S_DIVB: begin
        cmd.div_sel = 1'b1;
        if (sts.div_done) state_nxt = S_MLO;
      end
      S_MLO: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_go = 1'b1;
        cmd.mul_hi = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= RK_ZERO;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

// ===== rtl/npti_dp.sv =====
// sample tables, group and entry scans, interpolation arithmetic and result register
module npti_dp #(
  parameter int MAX_ENTRIES = npti_pkg::MAX_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  npti_pkg::cmd_t              cmd,
  output npti_pkg::sts_t              sts,
  input  logic                        cfg_valid,
  input  logic [npti_pkg::TOL_W-1:0]  cfg_fuzz_tolerance,
  input  logic signed [31:0]          in_coord_x,
  input  logic signed [31:0]          in_coord_y,
  input  logic signed [31:0]          in_coord_z,
  input  logic signed [31:0]          in_time_stamp,
  input  logic signed [31:0]          in_sample_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          out_interp_value,
  output logic signed [31:0]          out_time_slope,
  output logic [7:0]                  out_index_before,
  output logic [7:0]                  out_index_after,
  output logic signed [npti_pkg::WGT_W-1:0] out_weight_before,
  output logic signed [npti_pkg::WGT_W-1:0] out_weight_after,
  output logic [1:0]                  out_status
);
  import npti_pkg::*;

  localparam int IW  = $clog2(MAX_ENTRIES);
  localparam int CW  = IW + 1;
  localparam int IW8 = (IW > 8) ? IW : 8;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
  localparam logic [NUM_W-1:0] Q_MAXP = NUM_W'(64'd2147483647);
  localparam logic [NUM_W-1:0] Q_MAXN = NUM_W'(64'd2147483648);
  localparam logic [WGT_W-1:0] W_ONE  = WGT_W'(64'd1 << FRAC_BITS);

  // configuration and captured word
  logic [TOL_W-1:0]   tol_r;
  logic signed [31:0] cap_x_r, cap_y_r, cap_z_r, cap_t_r, cap_v_r;
  logic [CW-1:0]      ecnt_r, gcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(1);
    end else if (cfg_valid) begin
      tol_r <= cfg_fuzz_tolerance;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_x_r <= in_coord_x;
      cap_y_r <= in_coord_y;
      cap_z_r <= in_coord_z;
      cap_t_r <= in_time_stamp;
      cap_v_r <= in_sample_value;
    end
  end

  // memories: group representative points, per-entry time, value, group
  logic [31:0]   rep_x_m [MAX_ENTRIES];
  logic [31:0]   rep_y_m [MAX_ENTRIES];
  logic [31:0]   rep_z_m [MAX_ENTRIES];
  logic [31:0]   ent_t_m [MAX_ENTRIES];
  logic [31:0]   ent_v_m [MAX_ENTRIES];
  logic [IW-1:0] ent_g_m [MAX_ENTRIES];

  logic [CW-1:0]      gaddr_r, eaddr_r;
  logic               g_issue, e_issue;
  logic signed [31:0] rx_r, ry_r, rz_r;
  logic signed [31:0] et_r, ev_r;
  logic [IW-1:0]      eg_r;
  logic               found_r;
  logic [IW-1:0]      found_g_r;
  logic [IW-1:0]      new_g;

  assign g_issue = cmd.grp_run && (gaddr_r < gcnt_r);
  assign e_issue = cmd.ent_run && (eaddr_r < ecnt_r);
  assign new_g   = found_r ? found_g_r : gcnt_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_entry && !found_r) begin
      rep_x_m[gcnt_r[IW-1:0]] <= cap_x_r;
      rep_y_m[gcnt_r[IW-1:0]] <= cap_y_r;
      rep_z_m[gcnt_r[IW-1:0]] <= cap_z_r;
    end
    if (g_issue) begin
      rx_r <= rep_x_m[gaddr_r[IW-1:0]];
      ry_r <= rep_y_m[gaddr_r[IW-1:0]];
      rz_r <= rep_z_m[gaddr_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_entry) begin
      ent_t_m[ecnt_r[IW-1:0]] <= cap_t_r;
      ent_v_m[ecnt_r[IW-1:0]] <= cap_v_r;
      ent_g_m[ecnt_r[IW-1:0]] <= new_g;
    end
    if (e_issue) begin
      et_r <= ent_t_m[eaddr_r[IW-1:0]];
      ev_r <= ent_v_m[eaddr_r[IW-1:0]];
      eg_r <= ent_g_m[eaddr_r[IW-1:0]];
    end
  end

  // fill counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecnt_r <= '0;
      gcnt_r <= '0;
    end else if (cmd.clr) begin
      ecnt_r <= '0;
      gcnt_r <= '0;
    end else if (cmd.wr_entry) begin
      ecnt_r <= ecnt_r + 1'b1;
      if (!found_r) gcnt_r <= gcnt_r + 1'b1;
    end
  end

  // group scan pipeline: read, magnitudes, squares / L1, best compare
  logic          g1_vld_r, g2_vld_r, g3_vld_r;
  logic [IW-1:0] g1_idx_r, g2_idx_r, g3_idx_r;
  logic [31:0]   mx_r, my_r, mz_r;
  logic [63:0]   sqx_r, sqy_r, sqz_r;
  logic [65:0]   best_r;
  logic [IW-1:0] best_g_r;
  logic signed [32:0] dx, dy, dz;
  logic [33:0]   l1;
  logic [65:0]   sq_sum;

  always_comb begin
    dx     = 33'(cap_x_r) - 33'(rx_r);
    dy     = 33'(cap_y_r) - 33'(ry_r);
    dz     = 33'(cap_z_r) - 33'(rz_r);
    l1     = 34'(mx_r) + 34'(my_r) + 34'(mz_r);
    sq_sum = 66'(sqx_r) + 66'(sqy_r) + 66'(sqz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_vld_r <= 1'b0;
      g2_vld_r <= 1'b0;
      g3_vld_r <= 1'b0;
      gaddr_r  <= '0;
      found_r  <= 1'b0;
    end else if (cmd.capture) begin
      g1_vld_r <= 1'b0;
      g2_vld_r <= 1'b0;
      g3_vld_r <= 1'b0;
      gaddr_r  <= '0;
      found_r  <= 1'b0;
    end else begin
      g1_vld_r <= g_issue;
      g2_vld_r <= g1_vld_r;
      g3_vld_r <= g2_vld_r;
      if (g_issue) gaddr_r <= gaddr_r + 1'b1;
      // first group within tolerance wins
      if (g2_vld_r && !found_r && (l1 <= 34'(tol_r))) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    g1_idx_r <= gaddr_r[IW-1:0];
    g2_idx_r <= g1_idx_r;
    g3_idx_r <= g2_idx_r;
    mx_r     <= dx[32] ? 32'(-dx) : dx[31:0];
    my_r     <= dy[32] ? 32'(-dy) : dy[31:0];
    mz_r     <= dz[32] ? 32'(-dz) : dz[31:0];
    sqx_r    <= mx_r * mx_r;
    sqy_r    <= my_r * my_r;
    sqz_r    <= mz_r * mz_r;
    if (g2_vld_r && !found_r && (l1 <= 34'(tol_r))) found_g_r <= g2_idx_r;
    // nearest group, lowest number on ties
    if (g3_vld_r && ((g3_idx_r == '0) || (sq_sum < best_r))) begin
      best_r   <= sq_sum;
      best_g_r <= g3_idx_r;
    end
  end

  // entry scan: first, last and bracketing samples of the chosen group
  logic          e1_vld_r;
  logic [IW-1:0] e1_idx_r;
  logic [1:0]    cnt_r;
  logic          hb_r, ha_r;
  logic signed [31:0] f_t_r, f_v_r, l_t_r, l_v_r, b_t_r, b_v_r, a_t_r, a_v_r;
  logic [IW-1:0] f_i_r, l_i_r, b_i_r, a_i_r;
  logic signed [33:0] t34, tol34, t_lim;
  logic          e_hit, e_below;

  always_comb begin
    t34     = 34'(cap_t_r);
    tol34   = 34'(tol_r);
    t_lim   = t34 - tol34;
    e_hit   = e1_vld_r && (eg_r == best_g_r);
    e_below = 34'(et_r) < t_lim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
      eaddr_r  <= '0;
      cnt_r    <= '0;
      hb_r     <= 1'b0;
      ha_r     <= 1'b0;
    end else if (cmd.capture) begin
      e1_vld_r <= 1'b0;
      eaddr_r  <= '0;
      cnt_r    <= '0;
      hb_r     <= 1'b0;
      ha_r     <= 1'b0;
    end else begin
      e1_vld_r <= e_issue;
      if (e_issue) eaddr_r <= eaddr_r + 1'b1;
      if (e_hit) begin
        if (cnt_r != 2'd2) cnt_r <= cnt_r + 1'b1;
        if (e_below) hb_r <= 1'b1;
        else ha_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    e1_idx_r <= eaddr_r[IW-1:0];
    if (e_hit) begin
      if ((cnt_r == 2'd0) || (et_r < f_t_r)) begin
        f_t_r <= et_r;
        f_v_r <= ev_r;
        f_i_r <= e1_idx_r;
      end
      if ((cnt_r == 2'd0) || (et_r >= l_t_r)) begin
        l_t_r <= et_r;
        l_v_r <= ev_r;
        l_i_r <= e1_idx_r;
      end
      if (e_below && (!hb_r || (et_r >= b_t_r))) begin
        b_t_r <= et_r;
        b_v_r <= ev_r;
        b_i_r <= e1_idx_r;
      end
      if (!e_below && (!ha_r || (et_r < a_t_r))) begin
        a_t_r <= et_r;
        a_v_r <= ev_r;
        a_i_r <= e1_idx_r;
      end
    end
  end

  // bracket decision
  logic hold_first, hold_last;
  always_comb begin
    hold_first = (cnt_r == 2'd1) || (t34 <= 34'(f_t_r) + tol34);
    hold_last  = (t34 >= 34'(l_t_r) - tol34);
  end

  logic signed [31:0] sel_v_r, bv_r;
  logic [IW-1:0]      sel_i_r, bi_r, ai_r;
  logic [31:0]        dt_r, rel_r;
  logic signed [32:0] dv_r;
  logic signed [32:0] dt33, rel33;

  always_comb begin
    dt33  = 33'(a_t_r) - 33'(b_t_r);
    rel33 = 33'(cap_t_r) - 33'(b_t_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      sel_v_r <= hold_first ? f_v_r : l_v_r;
      sel_i_r <= hold_first ? f_i_r : l_i_r;
      bi_r    <= b_i_r;
      ai_r    <= a_i_r;
      bv_r    <= b_v_r;
      dt_r    <= dt33[31:0];
      rel_r   <= rel33[31:0];
      dv_r    <= 33'(a_v_r) - 33'(b_v_r);
    end
  end

  // shared divider: weight first, then slope magnitude
  logic [NUM_W-1:0] div_num, div_quo;
  logic             div_done;
  logic [31:0]      dv_mag;
  logic [WA_W-1:0]  wa_r;
  logic [NUM_W-1:0] sq_r;

  assign dv_mag  = dv_r[32] ? 32'(-dv_r) : dv_r[31:0];
  assign div_num = cmd.div_sel ? {dv_mag, FRAC_BITS'(0)} : {rel_r, FRAC_BITS'(0)};

  npti_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .num   (div_num),
    .den   (dt_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      if (cmd.div_sel) sq_r <= div_quo;
      else wa_r <= div_quo[WA_W-1:0];
    end
  end

  // value step times weight in two partial products
  logic signed [WA_W-WA_LO_W:0] mul_b;
  logic signed [50:0]           mul_p;
  logic signed [50:0]           p_lo_r, p_hi_r;

  assign mul_b = cmd.mul_hi ? $signed({1'b0, wa_r[WA_W-1:WA_LO_W]})
                            : $signed({1'b0, wa_r[WA_LO_W-1:0]});
  assign mul_p = dv_r * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      if (cmd.mul_hi) p_hi_r <= mul_p;
      else p_lo_r <= mul_p;
    end
  end

  // final value and slope with saturation
  logic signed [63:0] prod64, vsum;
  logic signed [31:0] val_r, slope_r, slope_c;

  always_comb begin
    prod64 = 64'(p_lo_r) + (64'(p_hi_r) <<< WA_LO_W);
    vsum   = (prod64 >>> FRAC_BITS) + 64'(bv_r);
    if (dv_r[32]) begin
      slope_c = (sq_r > Q_MAXN) ? 32'(S32_MIN) : -sq_r[31:0];
    end else begin
      slope_c = (sq_r > Q_MAXP) ? 32'(S32_MAX) : sq_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      if (vsum > S32_MAX) val_r <= 32'(S32_MAX);
      else if (vsum < S32_MIN) val_r <= 32'(S32_MIN);
      else val_r <= vsum[31:0];
      slope_r <= slope_c;
    end
  end

  // result word register
  logic                    out_valid_r;
  logic signed [31:0]      o_val_r, o_slope_r;
  logic [7:0]              o_bi_r, o_ai_r;
  logic [WGT_W-1:0]        o_wb_r, o_wa_r;
  logic [1:0]              o_st_r;
  logic [IW8-1:0]          sel_i8, bi8, ai8;

  assign sel_i8 = IW8'(sel_i_r);
  assign bi8    = IW8'(bi_r);
  assign ai8    = IW8'(ai_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_val_r   <= '0;
      o_slope_r <= '0;
      o_bi_r    <= '0;
      o_ai_r    <= '0;
      o_wb_r    <= '0;
      o_wa_r    <= '0;
      o_st_r    <= ST_OK;
      case (cmd.kind)
        RK_FULL:  o_st_r <= ST_FULL;
        RK_EMPTY: o_st_r <= ST_EMPTY;
        RK_HOLD: begin
          o_val_r <= sel_v_r;
          o_bi_r  <= sel_i8[7:0];
          o_ai_r  <= sel_i8[7:0];
          o_wb_r  <= W_ONE;
        end
        RK_INTERP: begin
          o_val_r   <= val_r;
          o_slope_r <= slope_r;
          o_bi_r    <= bi8[7:0];
          o_ai_r    <= ai8[7:0];
          o_wb_r    <= W_ONE - wa_r[WGT_W-1:0];
          o_wa_r    <= wa_r[WGT_W-1:0];
        end
        default: o_st_r <= ST_OK;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_interp_value  = o_val_r;
  assign out_time_slope    = o_slope_r;
  assign out_index_before  = o_bi_r;
  assign out_index_after   = o_ai_r;
  assign out_weight_before = $signed(o_wb_r);
  assign out_weight_after  = $signed(o_wa_r);
  assign out_status        = o_st_r;

  // status to controller
  always_comb begin
    sts.full     = (ecnt_r == CW'(MAX_ENTRIES));
    sts.empty    = (ecnt_r == '0);
    sts.grp_done = (gaddr_r == gcnt_r) && !g1_vld_r && !g2_vld_r && !g3_vld_r;
    sts.ent_done = (eaddr_r == ecnt_r) && !e1_vld_r;
    sts.bracket  = !hold_first && !hold_last;
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || out_ready;
  end

  // checks
  ap_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ecnt_r <= CW'(MAX_ENTRIES)) else $error("entry count beyond table depth");
  ap_grp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gcnt_r <= ecnt_r) else $error("more groups than entries");
  ap_wr_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_entry |=> ecnt_r == $past(ecnt_r) + 1'b1) else $error("load did not add one entry");
  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready)) else $error("result word overwritten");

endmodule

// ===== rtl/nearest_point_time_interpolator.sv =====
// top level of the nearest point time interpolator
//
//  channel  dir  handshake                 payload
//  in_      in   in_valid / in_ready       opcode, coord x y z, time stamp, sample value
//  out_     out  out_valid / out_ready     value, slope, indices, weights, status
//  cfg_     in   cfg_valid / cfg_ready     fuzz tolerance
//
// one word at a time. a clear empties the table; undefined opcodes and refused loads or
// queries go straight to the result; a load scans the G groups, one per cycle through the
// tolerance pipeline; a query scans the G groups and then the N entries, and an
// interpolating query then runs the bit-serial divider twice. reset empties the
// table with no sweep and sets the tolerance to 1. a held result word does not block
// the next input; that word waits only at its own output step.
module nearest_point_time_interpolator #(
  parameter int MAX_ENTRIES = npti_pkg::MAX_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_opcode,
  input  logic signed [31:0]                in_coord_x,
  input  logic signed [31:0]                in_coord_y,
  input  logic signed [31:0]                in_coord_z,
  input  logic signed [31:0]                in_time_stamp,
  input  logic signed [31:0]                in_sample_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_interp_value,
  output logic signed [31:0]                out_time_slope,
  output logic [7:0]                        out_index_before,
  output logic [7:0]                        out_index_after,
  output logic signed [npti_pkg::WGT_W-1:0] out_weight_before,
  output logic signed [npti_pkg::WGT_W-1:0] out_weight_after,
  output logic [1:0]                        out_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [npti_pkg::TOL_W-1:0]        cfg_fuzz_tolerance
);
  import npti_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // tolerance register always takes a write
  assign cfg_ready = 1'b1;

  npti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  npti_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_valid          (cfg_valid),
    .cfg_fuzz_tolerance (cfg_fuzz_tolerance),
    .in_coord_x         (in_coord_x),
    .in_coord_y         (in_coord_y),
    .in_coord_z         (in_coord_z),
    .in_time_stamp      (in_time_stamp),
    .in_sample_value    (in_sample_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_interp_value   (out_interp_value),
    .out_time_slope     (out_time_slope),
    .out_index_before   (out_index_before),
    .out_index_after    (out_index_after),
    .out_weight_before  (out_weight_before),
    .out_weight_after   (out_weight_after),
    .out_status         (out_status)
  );

endmodule

// ===== test/npti_checker.sv =====
// checker for the nearest point time interpolator: predicts and compares result words
`timescale 1ns / 100ps

module npti_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [1:0]                   in_opcode,
  input  logic signed [31:0]           in_coord_x,
  input  logic signed [31:0]           in_coord_y,
  input  logic signed [31:0]           in_coord_z,
  input  logic signed [31:0]           in_time_stamp,
  input  logic signed [31:0]           in_sample_value,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [31:0]           out_interp_value,
  input  logic signed [31:0]           out_time_slope,
  input  logic [7:0]                   out_index_before,
  input  logic [7:0]                   out_index_after,
  input  logic [npti_pkg::WGT_W-1:0]   out_weight_before,
  input  logic [npti_pkg::WGT_W-1:0]   out_weight_after,
  input  logic [1:0]                   out_status,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [npti_pkg::TOL_W-1:0]   cfg_fuzz_tolerance,
  output int                           fails,
  output int                           pending
);
  import npti_pkg::*;

  localparam int DEPTH = MAX_ENTRIES_DEF;
  localparam longint ONE = longint'(1) << FRAC_BITS;

  typedef struct {
    logic signed [31:0] value;
    logic signed [31:0] slope;
    logic [7:0]         idx_b;
    logic [7:0]         idx_a;
    logic [WGT_W-1:0]   wgt_b;
    logic [WGT_W-1:0]   wgt_a;
    logic [1:0]         status;
  } result_t;

  // shadow copy of the sample table
  longint tbl_x[DEPTH];
  longint tbl_y[DEPTH];
  longint tbl_z[DEPTH];
  longint tbl_t[DEPTH];
  longint tbl_v[DEPTH];
  int     tbl_grp[DEPTH];
  int     grp_first[DEPTH];
  int     n_entries;
  int     n_groups;
  longint tolerance;

  result_t expected_q[$];

  function automatic longint mag(input longint d);
    return (d < 0) ? -d : d;
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [65:0] sq66(input longint d);
    logic [65:0] m;
    m = 66'(mag(d));
    return m * m;
  endfunction

  // work out the result word for one accepted input word
  function automatic result_t lookup_word(input logic [1:0] op, input longint px, input longint py,
                                          input longint pz, input longint t, input longint v);
    result_t     r;
    int          g, i, j, r_idx, found, best, n, bi, ai;
    int          ord[DEPTH];
    logic [65:0] sq_dist, best_dist;
    longint      dt, rel, dv, wa, wb, value, slope;
    r = '{default: '0};
    best_dist = '0;
    best = 0;
    n = 0;
    case (op)
      OP_CLEAR: begin
        n_entries = 0;
        n_groups = 0;
      end
      OP_LOAD: begin
        if (n_entries >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          found = n_groups;
          for (g = 0; g < n_groups; g++) begin
            r_idx = grp_first[g];
            if (mag(px - tbl_x[r_idx]) + mag(py - tbl_y[r_idx]) + mag(pz - tbl_z[r_idx])
                <= tolerance) begin
              found = g;
              break;
            end
          end
          if (found == n_groups) begin
            grp_first[n_groups] = n_entries;
            n_groups++;
          end
          tbl_x[n_entries] = px;
          tbl_y[n_entries] = py;
          tbl_z[n_entries] = pz;
          tbl_t[n_entries] = t;
          tbl_v[n_entries] = v;
          tbl_grp[n_entries] = found;
          n_entries++;
        end
      end
      OP_QUERY: begin
        if (n_entries == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // nearest group, lowest number on ties
          for (g = 0; g < n_groups; g++) begin
            r_idx = grp_first[g];
            sq_dist = sq66(px - tbl_x[r_idx]) + sq66(py - tbl_y[r_idx])
                      + sq66(pz - tbl_z[r_idx]);
            if (g == 0 || sq_dist < best_dist) begin
              best = g;
              best_dist = sq_dist;
            end
          end
          // stable time order of that group's samples
          for (i = 0; i < n_entries; i++) begin
            if (tbl_grp[i] == best) begin
              j = n;
              while (j > 0 && tbl_t[ord[j-1]] > tbl_t[i]) begin
                ord[j] = ord[j-1];
                j--;
              end
              ord[j] = i;
              n++;
            end
          end
          // bracket the query time
          bi = ord[0];
          ai = ord[0];
          if (n == 1 || t <= tbl_t[ord[0]] + tolerance) begin
            bi = ord[0];
          end else if (t >= tbl_t[ord[n-1]] - tolerance) begin
            bi = ord[n-1];
            ai = ord[n-1];
          end else begin
            for (i = 1; i < n; i++) begin
              if (tbl_t[ord[i]] >= t - tolerance) begin
                bi = ord[i-1];
                ai = ord[i];
                break;
              end
            end
          end
          dt = tbl_t[ai] - tbl_t[bi];
          rel = t - tbl_t[bi];
          dv = tbl_v[ai] - tbl_v[bi];
          if (bi == ai || dt <= 0 || rel < 0) begin
            value = tbl_v[bi];
            slope = 0;
            wb = ONE;
            wa = 0;
          end else begin
            wa = (rel << FRAC_BITS) / dt;
            wb = ONE - wa;
            value = sat32(tbl_v[bi] + ((dv * wa) >>> FRAC_BITS));
            slope = sat32((dv * ONE) / dt);
          end
          r.value = value[31:0];
          r.slope = slope[31:0];
          r.idx_b = bi[7:0];
          r.idx_a = ai[7:0];
          r.wgt_b = wb[WGT_W-1:0];
          r.wgt_a = wa[WGT_W-1:0];
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // watch the three channels
  always @(posedge clk) begin
    result_t e;
    int      nf;
    nf = 0;
    if (!rst_n) begin
      n_entries <= 0;
      n_groups <= 0;
      tolerance <= 1;
      fails <= 0;
      pending <= 0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          nf++;
        end else begin
          e = expected_q.pop_front();
          if (out_interp_value !== e.value) begin
            $error("interp_value: expected %0d, got %0d", e.value, out_interp_value);
            nf++;
          end
          if (out_time_slope !== e.slope) begin
            $error("time_slope: expected %0d, got %0d", e.slope, out_time_slope);
            nf++;
          end
          if (out_index_before !== e.idx_b) begin
            $error("index_before: expected %0d, got %0d", e.idx_b, out_index_before);
            nf++;
          end
          if (out_index_after !== e.idx_a) begin
            $error("index_after: expected %0d, got %0d", e.idx_a, out_index_after);
            nf++;
          end
          if (out_weight_before !== e.wgt_b) begin
            $error("weight_before: expected %h, got %h", e.wgt_b, out_weight_before);
            nf++;
          end
          if (out_weight_after !== e.wgt_a) begin
            $error("weight_after: expected %h, got %h", e.wgt_a, out_weight_after);
            nf++;
          end
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status);
            nf++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_q.push_back(lookup_word(in_opcode, longint'(in_coord_x), longint'(in_coord_y),
                                         longint'(in_coord_z), longint'(in_time_stamp),
                                         longint'(in_sample_value)));
      end
      if (cfg_valid && cfg_ready) tolerance <= longint'(cfg_fuzz_tolerance);
      fails <= fails + nf;
      pending <= expected_q.size();
    end
  end

endmodule

// ===== test/nearest_point_time_interpolator_tb.sv =====
// testbench top for the nearest point time interpolator: stimulus and verdict
`timescale 1ns / 100ps

module nearest_point_time_interpolator_tb;
  import npti_pkg::*;

  localparam int LIMIT = 4000000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_opcode;
  logic signed [31:0]  in_coord_x;
  logic signed [31:0]  in_coord_y;
  logic signed [31:0]  in_coord_z;
  logic signed [31:0]  in_time_stamp;
  logic signed [31:0]  in_sample_value;
  logic                out_valid;
  logic                out_ready;
  logic signed [31:0]  out_interp_value;
  logic signed [31:0]  out_time_slope;
  logic [7:0]          out_index_before;
  logic [7:0]          out_index_after;
  logic signed [WGT_W-1:0] out_weight_before;
  logic signed [WGT_W-1:0] out_weight_after;
  logic [1:0]          out_status;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [TOL_W-1:0]    cfg_fuzz_tolerance;
  int                  fails;
  int                  pending;

  int  tx_idle;
  int  rx_idle;
  int  words_sent;
  int  cycles;
  int  cur_tol;
  bit  hold_req;
  bit  hold_on;

  nearest_point_time_interpolator dut (.*);

  npti_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .in_coord_x, .in_coord_y, .in_coord_z,
    .in_time_stamp, .in_sample_value, .out_valid, .out_ready, .out_interp_value,
    .out_time_slope, .out_index_before, .out_index_after,
    .out_weight_before(out_weight_before), .out_weight_after(out_weight_after), .out_status,
    .cfg_valid, .cfg_ready, .cfg_fuzz_tolerance, .fails, .pending
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // long receiver hold-off, counted here
  initial begin
    hold_on = 0;
    forever begin
      wait (hold_req);
      hold_on = 1;
      repeat (1500) @(posedge clk);
      hold_on = 0;
      hold_req = 0;
    end
  end

  // receiver stalls
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      out_ready = !hold_on && ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input logic [31:0] t, input logic [31:0] v);
    @(negedge clk);
    if ($urandom_range(99) < tx_idle) begin
      in_valid = 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1;
    in_opcode = op;
    in_coord_x = x;
    in_coord_y = y;
    in_coord_z = z;
    in_time_stamp = t;
    in_sample_value = v;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // sender pauses until every result word is back
  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    wait (pending == 0);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_tol(input int val);
    drain();
    cfg_valid = 1;
    cfg_fuzz_tolerance = val[TOL_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
    cur_tol = val;
  endtask

  function automatic logic [31:0] near_coord();
    return 32'($urandom_range(0, 8000)) - 32'd4000;
  endfunction

  // clear, then a cluster of loads and queries around a few points
  task automatic run_scene(input int n_loads, input int n_queries, input bit wide);
    logic [31:0] px[6], py[6], pz[6];
    int          k, np, loads_left, queries_left;
    logic [31:0] jit, tq;
    np = $urandom_range(1, 6);
    for (k = 0; k < np; k++) begin
      px[k] = wide ? $urandom : near_coord();
      py[k] = ($urandom_range(3) == 0) ? 32'd0 : (wide ? $urandom : near_coord());
      pz[k] = ($urandom_range(3) == 0) ? 32'd0 : (wide ? $urandom : near_coord());
    end
    send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    loads_left = n_loads;
    queries_left = n_queries;
    while (loads_left + queries_left > 0) begin
      k = $urandom_range(0, np - 1);
      if ($urandom_range(99) < 4) begin
        // noise word with any opcode and full-range fields
        send_word(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (loads_left > 0 && (queries_left == 0 || $urandom_range(3) != 0)) begin
        jit = (cur_tol > 2) ? 32'($urandom_range(0, cur_tol / 2)) : 32'd0;
        send_word(OP_LOAD, px[k] + jit, py[k], pz[k],
                  wide ? $urandom : 32'($urandom_range(0, 200000)),
                  ($urandom_range(1) == 0) ? $urandom : 32'($urandom_range(0, 600000)));
        loads_left--;
      end else begin
        tq = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, 240000)) - 32'd20000;
        send_word(OP_QUERY, px[k] + near_coord(), py[k], pz[k], tq, $urandom);
        queries_left--;
      end
    end
  endtask

  task automatic run_phase(input int tx, input int rx, input int target, input bit pressure);
    tx_idle = tx;
    rx_idle = rx;
    while (words_sent < target) begin
      if (pressure && words_sent > target - 200) begin
        hold_req = 1;
        pressure = 0;
      end
      run_scene($urandom_range(1, 20), $urandom_range(1, 14), $urandom_range(4) == 0);
      if ($urandom_range(3) == 0) drain();
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_opcode = OP_CLEAR;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    in_time_stamp = '0;
    in_sample_value = '0;
    cfg_valid = 0;
    cfg_fuzz_tolerance = '0;
    tx_idle = 0;
    rx_idle = 0;
    words_sent = 0;
    hold_req = 0;
    cur_tol = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: empty table, undefined opcode, hold, interpolation, extremes, ties
    write_tol(1);
    send_word(OP_QUERY, 0, 0, 0, 0, 0);
    send_word(2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_word(OP_LOAD, 0, 0, 0, 0, 32'd100 << 16);
    send_word(OP_QUERY, 0, 0, 0, 5, 0);
    send_word(OP_LOAD, 1, 0, 0, 32'd10 << 16, -(32'd50 << 16));
    send_word(OP_LOAD, 0, 0, 0, 32'd20 << 16, 32'h7fffffff);
    send_word(OP_QUERY, 0, 0, 0, 32'h80000000, 0);
    send_word(OP_QUERY, 0, 0, 0, 32'd5 << 16, 0);
    send_word(OP_QUERY, 0, 0, 0, 32'd15 << 16, 0);
    send_word(OP_QUERY, 0, 0, 0, 32'h7fffffff, 0);
    send_word(OP_LOAD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
    send_word(OP_LOAD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_word(OP_QUERY, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0);
    send_word(OP_QUERY, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
    send_word(OP_LOAD, 0, 0, 0, 32'd10 << 16, 32'd7);
    send_word(OP_QUERY, 0, 0, 0, 32'd10 << 16, 0);
    send_word(OP_QUERY, 0, 0, 0, (32'd10 << 16) + 1, 0);
    send_word(OP_LOAD, 2, 0, 0, 0, 32'd3);
    send_word(OP_QUERY, 1, 0, 0, 32'd3, 0);
    send_word(OP_CLEAR, 0, 0, 0, 0, 0);
    send_word(OP_QUERY, 0, 0, 0, 0, 0);

    // random: receiver idles often first, then the sender, then neither
    write_tol(0);
    run_phase(21, 79, 350, 1);
    write_tol(65535);
    run_phase(79, 21, 700, 0);
    write_tol($urandom_range(2, 65534));
    tx_idle = 0;
    rx_idle = 0;
    // fill past the table depth
    run_scene(258, 3, 0);
    write_tol(1000);
    run_phase(0, 0, 1050, 0);

    drain();
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
